@@ hw/rtl/mksd_pkg.sv @@
// ----------------------------------------------------------------------------
// mksd_pkg: shared definitions for the keypad scan and debounce block
// Field widths, reset constants and the fixed key priority encoder.
// ----------------------------------------------------------------------------
package mksd_pkg;

    localparam int NUM_COLUMNS_DEF = 4;
    localparam int NUM_ROWS_DEF    = 2;

    localparam int ROW_W     = 2;   // row_sense width
    localparam int COL_W     = 4;   // column_drive width
    localparam int COL_IDX_W = 2;   // column index width
    localparam int PAT_W     = 8;   // scan pattern width
    localparam int KEY_W     = 5;   // key_code width
    localparam int CNT_W     = 8;   // debounce counter width

    localparam int S_DATA_W = 8;    // row_sense padded to a byte
    localparam int M_DATA_W = 24;   // 17 payload bits padded to whole bytes

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd10;
    localparam logic [KEY_W-1:0] NO_KEY         = 5'd30;
    localparam logic [COL_W-1:0] COLUMN_MASK    = 4'hF;

    typedef logic [KEY_W-1:0] key_code_t;

    // Key number for each pattern bit; bit 0 has the highest priority.
    localparam key_code_t KEY_MAP [PAT_W] = '{
        5'd10, 5'd11, 5'd3, 5'd6, 5'd2, 5'd5, 5'd1, 5'd4
    };

    function automatic key_code_t encode_key(input logic [PAT_W-1:0] pat);
        key_code_t code;
        code = NO_KEY;
        for (int b = PAT_W - 1; b >= 0; b--) begin
            if (pat[b]) begin
                code = KEY_MAP[b];
            end
        end
        return code;
    endfunction

endpackage

@@ hw/rtl/matrix_keypad_scan_debounce.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce: column scanner with debounce and key encoder
// Takes one row sample per scan tick, assembles the key bitmap over a full
// column sweep, debounces it against the previous sweep and encodes the key.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (low bit first)                    Handshake
//  --------  ---------  -----------------------------------------  ------------
//  s_axis    in         row_sense[1:0], zero pad to 8 bits         tvalid/tready
//  m_axis    out        column_drive[3:0], stable_pattern[11:4],   tvalid/tready
//                       key_code[16:12], zero pad to 24 bits
//  cfg       in         debounce_count[7:0]                        valid/ready
//
//  One item per clock sustained while m_axis is ready: each item passes an input
//  register, then a single compute stage that updates the scan state and loads
//  the result register, which drives m_axis_tvalid and m_axis_tdata.
//  Reset (aresetn low, synchronous) clears all scan state, empties both
//  stages and sets debounce_count to 10; the first sample is taken as column 0.
//  A stalled m_axis holds the result and, with the input register full,
//  drops s_axis_tready; no item is lost. cfg is always ready.
//
module matrix_keypad_scan_debounce #(
    parameter int NUM_COLUMNS = mksd_pkg::NUM_COLUMNS_DEF,  // 1..4
    parameter int NUM_ROWS    = mksd_pkg::NUM_ROWS_DEF      // 1..2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // fields: row_sense[1:0]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mksd_pkg::S_DATA_W-1:0] s_axis_tdata,
    // fields: column_drive[3:0], stable_pattern[11:4], key_code[16:12]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mksd_pkg::M_DATA_W-1:0] m_axis_tdata,
    // debounce_count write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mksd_pkg::CNT_W-1:0]    cfg_data
);
    import mksd_pkg::*;

    localparam logic [COL_IDX_W-1:0] COL_LAST = COL_IDX_W'(NUM_COLUMNS - 1);
    localparam int PAD_W = M_DATA_W - COL_W - PAT_W - KEY_W;

    // Configuration
    logic [CNT_W-1:0] debounce_count_reg;

    // Input register
    logic             in_valid_reg;
    logic [ROW_W-1:0] row_reg;

    // Scan state
    logic [COL_IDX_W-1:0] column_index_reg, column_index_next;
    logic [PAT_W-1:0]     scan_pattern_reg, scan_pattern_next;
    logic [PAT_W-1:0]     previous_pattern_reg, previous_pattern_next;
    logic [CNT_W-1:0]     countdown_reg, countdown_next;
    logic [PAT_W-1:0]     debounced_pattern_reg, debounced_pattern_next;

    // Result register
    logic                out_valid_reg;
    logic [COL_W-1:0]    column_drive_reg, column_drive_next;
    logic [PAT_W-1:0]    stable_reg;
    key_code_t           key_code_reg;

    logic advance;
    logic last_col;

    // Move the input register forward whenever the result slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign last_col = (column_index_reg == COL_LAST);

    // Next scan state for the item in the input register
    always_comb begin
        // Update only the bits of the column being sampled; pressed is low
        scan_pattern_next = scan_pattern_reg;
        for (int b = 0; b < PAT_W; b++) begin
            if (COL_IDX_W'(b >> 1) == column_index_reg && (b % 2) < NUM_ROWS) begin
                scan_pattern_next[b] = ~row_reg[b % 2];
            end
        end

        column_index_next      = last_col ? '0 : column_index_reg + 1'b1;
        previous_pattern_next  = previous_pattern_reg;
        countdown_next         = countdown_reg;
        debounced_pattern_next = debounced_pattern_reg;

        // Compare once per full sweep
        if (last_col) begin
            if (scan_pattern_next == previous_pattern_reg) begin
                if (countdown_reg != '0) begin
                    countdown_next = countdown_reg - 1'b1;
                end
            end else begin
                countdown_next        = debounce_count_reg;
                previous_pattern_next = scan_pattern_next;
            end
            if (countdown_next == '0) begin
                debounced_pattern_next = previous_pattern_next;
            end
        end

        column_drive_next = COLUMN_MASK & ~(COL_W'(1) << column_index_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_count_reg    <= DEBOUNCE_RESET;
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            column_index_reg      <= '0;
            scan_pattern_reg      <= '0;
            previous_pattern_reg  <= '0;
            countdown_reg         <= '0;
            debounced_pattern_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                debounce_count_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg         <= 1'b1;
                column_index_reg      <= column_index_next;
                scan_pattern_reg      <= scan_pattern_next;
                previous_pattern_reg  <= previous_pattern_next;
                countdown_reg         <= countdown_next;
                debounced_pattern_reg <= debounced_pattern_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            row_reg <= s_axis_tdata[ROW_W-1:0];
        end
        if (advance) begin
            column_drive_reg <= column_drive_next;
            stable_reg       <= debounced_pattern_next;
            key_code_reg     <= encode_key(debounced_pattern_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, key_code_reg, stable_reg, column_drive_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        column_index_reg <= COL_LAST)
        else $error("column index beyond last column");

    a_stable_mid_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !last_col |=> $stable(debounced_pattern_reg))
        else $error("debounced pattern changed mid sweep");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && last_col && scan_pattern_next == previous_pattern_reg
            && countdown_reg != '0
        |=> countdown_reg == $past(countdown_reg) - 1'b1)
        else $error("countdown did not step down on equal sweep");

    a_key_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> key_code_reg == encode_key(stable_reg))
        else $error("key code does not match stable pattern");

    a_drive_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) |-> column_drive_reg
            == (COLUMN_MASK & ~(COL_W'(1) << column_index_reg)))
        else $error("column drive does not select the next column");

endmodule
